[src/sbhm_pkg.sv]
// ----------------------------------------------------------------------------
// sbhm_pkg
// Shared constants and types of the source block health monitor.
// ----------------------------------------------------------------------------
package sbhm_pkg;
	localparam int SOURCES            = 256;
	localparam int CYCLES_PER_SUMMARY = 16;
	localparam int IDX_W              = $clog2(SOURCES);
	localparam int CNT_W              = (CYCLES_PER_SUMMARY > 1) ? $clog2(CYCLES_PER_SUMMARY) : 1;
	localparam int UNIQ_W             = 9;

	typedef enum logic [2:0] {
		ACT_LOAD  = 3'd0,
		ACT_BEGIN = 3'd1,
		ACT_HDR   = 3'd2,
		ACT_END   = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_READ  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_READOUT = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	localparam logic [14:0] ST_SKIP = 15'h0bad;
	localparam logic [14:0] ST_CFG  = 15'h2000;
	localparam logic [14:0] ST_DATA = 15'h4000;

	// one entry of the per-source table
	typedef struct packed {
		logic [31:0] exp_crc;
		logic [14:0] status;
		logic [31:0] err_sec;
		logic [31:0] err_tot;
		logic        f_seen;
		logic        f_this;
		logic        f_proc;
	} entry_t;
endpackage

[src/sbhm_table.sv]
// ----------------------------------------------------------------------------
// sbhm_table
// Per-source table: one synchronous RAM, one read and one write port.
// ----------------------------------------------------------------------------
module sbhm_table
	import sbhm_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);
	entry_t mem [SOURCES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[src/source_block_health_monitor.sv]
// ----------------------------------------------------------------------------
// source_block_health_monitor
// Per-source CRC health table with periodic summaries.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// command  | start & !busy      | action, source_id, crc, byte and count fields
// result   | done (one cycle)   | kind, readout fields, summary fields
//
// Steps from one accepted transfer to the earliest next one:
// Clear, unknown actions and an end with no open cycle: the response. Load
// and read in range and a good header: RAM read, modify and write, response.
// Begin, an open end and a bad-id abort sweep all SOURCES entries through the
// RAM; an overflow abort adds that sweep after its header. A summary end makes
// a second sweep. After reset a clearing pass over all SOURCES entries runs
// with busy high. The receiver cannot stall: done is a single pulse.
// ----------------------------------------------------------------------------
module source_block_health_monitor
	import sbhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] source_id,
	input  logic [31:0] config_crc,
	input  logic [31:0] data_crc_reported,
	input  logic [31:0] data_crc_computed,
	input  logic [31:0] model_bytes,
	input  logic [31:0] testpoint_bytes,
	input  logic [15:0] testpoint_count,
	input  logic [31:0] time_seconds,
	input  logic [15:0] model_count,
	input  logic [31:0] block_bytes,
	output logic        done,
	output logic [1:0]  kind,
	output logic [14:0] source_status,
	output logic [31:0] errors_this_second,
	output logic [31:0] errors_total,
	output logic [30:0] uptime_count,
	output logic [31:0] gps_seconds,
	output logic [31:0] testpoint_kib,
	output logic [31:0] model_kib,
	output logic [31:0] total_kib,
	output logic [31:0] open_testpoints,
	output logic [8:0]  unique_sources
);
	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_RMW_RD, S_RMW_WR, S_SWEEP, S_RESP
	} state_t;

	// sweep flavors
	typedef enum logic [2:0] {
		SW_BEGIN_OK, SW_BEGIN_BAD, SW_SKIP, SW_END_MARK, SW_SUMMARY
	} sweep_t;

	state_t            state_q;
	sweep_t            sweep_q;
	logic [IDX_W:0]    ptr_q;       // sweep read pointer, MSB = read done
	logic              wv_s1;       // sweep write pipeline valid
	logic [IDX_W-1:0]  wa_s1;
	logic              end_then_sum_q;

	// latched command
	action_t           act_q;
	logic [15:0]       id_q;
	logic [31:0]       ccrc_q, drep_q, dcmp_q, mb_q, tb_q, tm_q;
	logic [15:0]       tpc_q;

	// cycle and summary state
	logic [CNT_W-1:0]  cyc_q;
	logic [32:0]       off_q;
	logic              c_valid_q, c_abort_q, c_first_q, c_clear_q;
	logic [63:0]       acc_tb_q, acc_mb_q, acc_bb_q;
	logic [30:0]       uptime_q;
	logic [31:0]       gps_q, tpsum_q, bsize_q;
	logic [UNIQ_W-1:0] uniq_q;

	// RAM
	logic              rd_en, wr_en;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	entry_t            rd_data, wr_data;

	sbhm_table u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	logic [33:0] need;
	assign need = {1'b0, off_q} + 34'(mb_q) + 34'(tb_q);

	// per-entry sweep update; the header rmw update is hdr_new below
	entry_t sw_new;
	always_comb begin
		sw_new = rd_data;
		unique case (sweep_q)
			SW_BEGIN_OK: sw_new.f_this = 1'b0;
			SW_BEGIN_BAD: begin
				sw_new.f_this  = 1'b0;
				sw_new.err_sec = rd_data.err_sec + 32'd1;
				sw_new.err_tot = rd_data.err_tot + 32'd1;
			end
			SW_SKIP, SW_END_MARK: begin
				if (!rd_data.f_this) begin
					if (rd_data.f_seen) begin
						sw_new.err_sec = rd_data.err_sec + 32'd1;
						sw_new.err_tot = rd_data.err_tot + 32'd1;
					end
					sw_new.status = rd_data.status | ST_SKIP;
					if (sweep_q == SW_END_MARK) begin
						sw_new.f_seen = 1'b0;
					end
				end
			end
			SW_SUMMARY: begin
				sw_new.err_sec = '0;
				sw_new.status  = '0;
				sw_new.f_proc  = 1'b0;
				if (c_clear_q) begin
					sw_new.err_tot = '0;
				end
			end
			default: ;
		endcase
	end

	entry_t hdr_new;
	logic   hdr_ovf;
	assign hdr_ovf = need > 34'(bsize_q);
	always_comb begin
		hdr_new = rd_data;
		hdr_new.f_proc = 1'b1;
		hdr_new.f_this = 1'b1;
		if (ccrc_q != rd_data.exp_crc) begin
			hdr_new.status = hdr_new.status | ST_CFG;
		end
		if (!hdr_ovf) begin
			hdr_new.f_seen = 1'b1;
			if (drep_q != dcmp_q) begin
				hdr_new.err_sec = rd_data.err_sec + 32'd1;
				hdr_new.err_tot = rd_data.err_tot + 32'd1;
				hdr_new.status  = hdr_new.status | ST_DATA;
			end
		end
	end

	logic sweeping;
	assign sweeping = (state_q == S_SWEEP);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = id_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = wa_s1;
		wr_data = sw_new;
		if (state_q == S_INIT) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q[IDX_W-1:0];
			wr_data = '0;
		end else if (sweeping) begin
			rd_en   = !ptr_q[IDX_W];
			rd_addr = ptr_q[IDX_W-1:0];
			wr_en   = wv_s1;
		end else if (state_q == S_RMW_RD) begin
			rd_en = 1'b1;
		end else if (state_q == S_RMW_WR && act_q == ACT_HDR) begin
			wr_en   = 1'b1;
			wr_addr = id_q[IDX_W-1:0];
			wr_data = hdr_new;
		end
		if (state_q == S_RMW_WR && act_q == ACT_LOAD) begin
			wr_en   = 1'b1;
			wr_addr = id_q[IDX_W-1:0];
			wr_data = rd_data;
			wr_data.exp_crc = ccrc_q;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= SW_BEGIN_OK;
			ptr_q <= '0;
			wv_s1 <= 1'b0;
			end_then_sum_q <= 1'b0;
			cyc_q <= '0;
			off_q <= '0;
			c_valid_q <= 1'b0;
			c_abort_q <= 1'b0;
			c_first_q <= 1'b0;
			c_clear_q <= 1'b0;
			acc_tb_q <= '0;
			acc_mb_q <= '0;
			acc_bb_q <= '0;
			uptime_q <= '0;
			gps_q <= '0;
			tpsum_q <= '0;
			bsize_q <= '0;
			uniq_q <= '0;
			done <= 1'b0;
			kind <= KIND_ACK;
			act_q <= ACT_LOAD;
		end else begin
			done <= 1'b0;
			wv_s1 <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[IDX_W-1:0] == IDX_W'(SOURCES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q <= action_t'(action);
						id_q <= source_id;
						ccrc_q <= config_crc;
						drep_q <= data_crc_reported;
						dcmp_q <= data_crc_computed;
						mb_q <= model_bytes;
						tb_q <= testpoint_bytes;
						tpc_q <= testpoint_count;
						tm_q <= time_seconds;
						ptr_q <= '0;
						end_then_sum_q <= 1'b0;
						state_q <= S_RESP;
						case (action)
							ACT_LOAD, ACT_READ: begin
								if (source_id < 16'(SOURCES)) state_q <= S_RMW_RD;
							end
							ACT_BEGIN: begin
								cyc_q <= (cyc_q == CNT_W'(CYCLES_PER_SUMMARY - 1)) ? '0
									: cyc_q + 1'b1;
								tpsum_q <= '0;
								state_q <= S_SWEEP;
								if (model_count == 16'd0 || model_count > 16'(SOURCES)
									|| block_bytes == 32'd0) begin
									sweep_q <= SW_BEGIN_BAD;
									c_valid_q <= 1'b0;
									c_abort_q <= 1'b0;
									c_first_q <= 1'b0;
								end else begin
									sweep_q <= SW_BEGIN_OK;
									c_valid_q <= 1'b1;
									c_abort_q <= 1'b0;
									c_first_q <= 1'b1;
									acc_bb_q <= acc_bb_q + 64'(block_bytes);
									off_q <= '0;
									bsize_q <= block_bytes;
								end
							end
							ACT_HDR: begin
								if (c_valid_q && !c_abort_q) begin
									if (source_id == 16'd0 || source_id >= 16'(SOURCES)) begin
										if (model_bytes != 0 || testpoint_bytes != 0) begin
											sweep_q <= SW_SKIP;
											c_abort_q <= 1'b1;
											state_q <= S_SWEEP;
										end
									end else begin
										state_q <= S_RMW_RD;
									end
								end
							end
							ACT_END: begin
								if (c_valid_q) begin
									c_valid_q <= 1'b0;
									c_abort_q <= 1'b0;
									c_first_q <= 1'b0;
									sweep_q <= SW_END_MARK;
									end_then_sum_q <= (cyc_q == '0);
									state_q <= S_SWEEP;
								end
							end
							ACT_CLEAR: c_clear_q <= 1'b1;
							default: ;
						endcase
					end
				end
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: begin
					state_q <= S_RESP;
					if (act_q == ACT_HDR) begin
						tpsum_q <= tpsum_q + 32'(tpc_q);
						acc_tb_q <= acc_tb_q + 64'(tb_q);
						acc_mb_q <= acc_mb_q + 64'(mb_q);
						if (c_first_q) begin
							gps_q <= tm_q;
							c_first_q <= 1'b0;
						end
						if (hdr_ovf) begin
							c_abort_q <= 1'b1;
							sweep_q <= SW_SKIP;
							ptr_q <= '0;
							state_q <= S_SWEEP;
						end else begin
							off_q <= need[32:0];
						end
					end
				end
				S_SWEEP: begin
					if (!ptr_q[IDX_W]) begin
						ptr_q <= ptr_q + 1'b1;
						wv_s1 <= 1'b1;
						wa_s1 <= ptr_q[IDX_W-1:0];
						if (ptr_q[IDX_W-1:0] == IDX_W'(SOURCES - 1)) begin
							ptr_q[IDX_W] <= 1'b1;
						end
					end
					if (wv_s1 && sweep_q == SW_END_MARK && rd_data.f_proc) begin
						uniq_q <= uniq_q + 1'b1;
					end
					if (ptr_q[IDX_W] && !wv_s1) begin
						if (end_then_sum_q) begin
							end_then_sum_q <= 1'b0;
							sweep_q <= SW_SUMMARY;
							ptr_q <= '0;
							uptime_q <= uptime_q + 1'b1;
							kind <= KIND_SUMMARY;
						end else begin
							if (sweep_q == SW_SUMMARY) begin
								acc_tb_q <= '0;
								acc_mb_q <= '0;
								acc_bb_q <= '0;
								c_clear_q <= 1'b0;
								uniq_q <= '0;
								done <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								if (sweep_q == SW_END_MARK) uniq_q <= '0;
								kind <= KIND_ACK;
								state_q <= S_RESP;
							end
						end
					end
				end
				S_RESP: begin
					done <= 1'b1;
					kind <= (act_q == ACT_READ) ? KIND_READOUT : KIND_ACK;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// summary snapshot
	logic [UNIQ_W-1:0] uniq_s1;
	logic [31:0] tkib_s1, mkib_s1, bkib_s1;
	always_ff @(posedge clk) begin
		if (sweeping && ptr_q[IDX_W] && !wv_s1 && end_then_sum_q) begin
			tkib_s1 <= acc_tb_q[41:10];
			mkib_s1 <= acc_mb_q[41:10];
			bkib_s1 <= acc_bb_q[41:10];
			uniq_s1 <= uniq_q;
		end
	end

	// readout capture; zero while idle so an out-of-range read reports zeros
	logic [14:0] rs_q;
	logic [31:0] re_q, rt_q;
	always_ff @(posedge clk) begin
		if (state_q == S_RMW_WR) begin
			rs_q <= rd_data.status;
			re_q <= rd_data.err_sec;
			rt_q <= rd_data.err_tot;
		end else if (state_q == S_IDLE) begin
			rs_q <= '0;
			re_q <= '0;
			rt_q <= '0;
		end
	end

	logic is_rd, is_sum;
	assign is_rd  = (kind == KIND_READOUT);
	assign is_sum = (kind == KIND_SUMMARY);
	assign source_status      = is_rd ? rs_q : '0;
	assign errors_this_second = is_rd ? re_q : '0;
	assign errors_total       = is_rd ? rt_q : '0;
	assign uptime_count       = is_sum ? uptime_q : '0;
	assign gps_seconds        = is_sum ? gps_q : '0;
	assign testpoint_kib      = is_sum ? tkib_s1 : '0;
	assign model_kib          = is_sum ? mkib_s1 : '0;
	assign total_kib          = is_sum ? bkib_s1 : '0;
	assign open_testpoints    = is_sum ? tpsum_q : '0;
	assign unique_sources     = is_sum ? uniq_s1 : '0;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> busy) else $error("idle during sweep");
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !done) else $error("result during clear");
`endif
endmodule

[tb/sv/source_block_health_monitor_tb.sv]
// ----------------------------------------------------------------------------
// source_block_health_monitor_tb
// Self-checking bench for the source block health monitor. A directed table
// hits the corner cases first: reset readout, ids outside the table, bad
// begins, header aborts, double charging and unknown actions. Randomized
// data cycles follow, with noise items mixed in. Every result is checked
// field by field against a hand-written expectation or the in-bench per-source table model.
// ----------------------------------------------------------------------------
module source_block_health_monitor_tb;
	import sbhm_pkg::*;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam int         N_ITEMS       = 1150;

	typedef struct {
		logic [2:0]  act;
		logic [15:0] sid;
		logic [31:0] cfg;
		logic [31:0] drep;
		logic [31:0] dcmp;
		logic [31:0] mb;
		logic [31:0] tb;
		logic [15:0] tpc;
		logic [31:0] tsec;
		logic [15:0] mc;
		logic [31:0] bb;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [14:0] status;
		logic [31:0] err_sec;
		logic [31:0] err_tot;
		logic [30:0] uptime;
		logic [31:0] gps;
		logic [31:0] tp_kib;
		logic [31:0] mod_kib;
		logic [31:0] tot_kib;
		logic [31:0] open_tp;
		logic [8:0]  uniq;
	} health_t;

	// directed row: command plus an optional hand-written expectation
	typedef struct {
		cmd_t    c;
		bit      typed;
		health_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = '0;
	logic [15:0] source_id = '0;
	logic [31:0] config_crc = '0;
	logic [31:0] data_crc_reported = '0;
	logic [31:0] data_crc_computed = '0;
	logic [31:0] model_bytes = '0;
	logic [31:0] testpoint_bytes = '0;
	logic [15:0] testpoint_count = '0;
	logic [31:0] time_seconds = '0;
	logic [15:0] model_count = '0;
	logic [31:0] block_bytes = '0;
	logic        done;
	logic [1:0]  kind;
	logic [14:0] source_status;
	logic [31:0] errors_this_second;
	logic [31:0] errors_total;
	logic [30:0] uptime_count;
	logic [31:0] gps_seconds;
	logic [31:0] testpoint_kib;
	logic [31:0] model_kib;
	logic [31:0] total_kib;
	logic [31:0] open_testpoints;
	logic [8:0]  unique_sources;

	source_block_health_monitor u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// in-bench copy of the health table
	// ------------------------------------------------------------------
	logic [31:0] crc_tbl [SOURCES];
	logic [14:0] stat_tbl [SOURCES];
	logic [31:0] esec_tbl [SOURCES];
	logic [31:0] etot_tbl [SOURCES];
	bit          f_proc [SOURCES];
	bit          f_this [SOURCES];
	bit          f_seen [SOURCES];
	int unsigned       cyc_cnt;
	longint unsigned   offs;
	bit                c_valid, c_abort, c_first, c_clear;
	longint unsigned   acc_tp, acc_mod, acc_blk;
	logic [31:0]       uptime, gps_reg, open_tp, blk_size;

	health_t health_q[$];
	int      n_items, n_bad, n_summaries, n_readouts, n_aborts;

	function automatic void charge_src(int i);
		esec_tbl[i]++;
		etot_tbl[i]++;
	endfunction

	// sources not seen this cycle are skipped; charge one error if seen before
	function automatic void skip_unseen();
		for (int i = 0; i < SOURCES; i++) begin
			if (!f_this[i]) begin
				if (f_seen[i])
					charge_src(i);
				stat_tbl[i] |= ST_SKIP;
			end
		end
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < SOURCES; i++) begin
			crc_tbl[i] = '0; stat_tbl[i] = '0; esec_tbl[i] = '0; etot_tbl[i] = '0;
			f_proc[i] = 0; f_this[i] = 0; f_seen[i] = 0;
		end
		cyc_cnt = 0; offs = 0;
		c_valid = 0; c_abort = 0; c_first = 0; c_clear = 0;
		acc_tp = 0; acc_mod = 0; acc_blk = 0;
		uptime = '0; gps_reg = '0; open_tp = '0; blk_size = '0;
	endfunction

	function automatic void header_step(cmd_t c);
		longint unsigned sz;
		int              s;
		sz = {32'b0, c.mb} + {32'b0, c.tb};
		if (!c_valid || c_abort)
			return;
		if (c.sid == 0 || c.sid >= SOURCES) begin
			// bad id matters only when it carries data
			if (sz != 0) begin
				skip_unseen();
				c_abort = 1;
				n_aborts++;
			end
			return;
		end
		s = c.sid;
		open_tp += {16'b0, c.tpc};
		acc_tp += c.tb;
		acc_mod += c.mb;
		f_proc[s] = 1;
		f_this[s] = 1;
		if (c_first) begin
			gps_reg = c.tsec;
			c_first = 0;
		end
		if (c.cfg != crc_tbl[s])
			stat_tbl[s] |= ST_CFG;
		// overflow: counts already taken, source stays unseen
		if (offs + sz > {32'b0, blk_size}) begin
			skip_unseen();
			c_abort = 1;
			n_aborts++;
			return;
		end
		f_seen[s] = 1;
		if (c.drep != c.dcmp) begin
			charge_src(s);
			stat_tbl[s] |= ST_DATA;
		end
		offs += sz;
	endfunction

	function automatic health_t end_step();
		health_t     r;
		logic [31:0] u;
		r = '0;
		u = '0;
		if (!c_valid)
			return r;
		c_valid = 0; c_abort = 0; c_first = 0;
		skip_unseen();
		for (int i = 0; i < SOURCES; i++)
			if (!f_this[i])
				f_seen[i] = 0;
		if (cyc_cnt != 0)
			return r;
		uptime++;
		for (int i = 0; i < SOURCES; i++)
			if (f_proc[i])
				u++;
		r.kind    = KIND_SUMMARY;
		r.uptime  = uptime[30:0];
		r.gps     = gps_reg;
		r.tp_kib  = 32'(acc_tp / 1024);
		r.mod_kib = 32'(acc_mod / 1024);
		r.tot_kib = 32'(acc_blk / 1024);
		r.open_tp = open_tp;
		r.uniq    = u[8:0];
		for (int i = 0; i < SOURCES; i++) begin
			esec_tbl[i] = '0;
			stat_tbl[i] = '0;
			f_proc[i] = 0;
			if (c_clear)
				etot_tbl[i] = '0;
		end
		acc_tp = 0; acc_mod = 0; acc_blk = 0;
		c_clear = 0;
		return r;
	endfunction

	function automatic health_t health_step(cmd_t c);
		health_t r;
		r = '0;
		case (c.act)
			ACT_LOAD: begin
				if (c.sid < SOURCES)
					crc_tbl[c.sid] = c.cfg;
			end
			ACT_BEGIN: begin
				cyc_cnt = (cyc_cnt + 1) % CYCLES_PER_SUMMARY;
				open_tp = '0;
				for (int i = 0; i < SOURCES; i++)
					f_this[i] = 0;
				if (c.mc == 0 || c.mc > SOURCES || c.bb == 0) begin
					for (int i = 0; i < SOURCES; i++)
						charge_src(i);
					c_valid = 0; c_abort = 0; c_first = 0;
				end else begin
					c_valid = 1; c_abort = 0; c_first = 1;
					acc_blk += c.bb;
					offs = 0;
					blk_size = c.bb;
				end
			end
			ACT_HDR:   header_step(c);
			ACT_END:   r = end_step();
			ACT_CLEAR: c_clear = 1;
			ACT_READ: begin
				r.kind = KIND_READOUT;
				if (c.sid < SOURCES) begin
					r.status  = stat_tbl[c.sid];
					r.err_sec = esec_tbl[c.sid];
					r.err_tot = etot_tbl[c.sid];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------
	function automatic cmd_t mk(logic [2:0] a, logic [15:0] id = 0, logic [31:0] cfg = 0,
	                            logic [31:0] mb = 0, logic [31:0] tb = 0,
	                            logic [15:0] mc = 0, logic [31:0] bb = 0);
		cmd_t c;
		c = '{act: a, sid: id, cfg: cfg, drep: 0, dcmp: 0, mb: mb, tb: tb,
		      tpc: 0, tsec: 0, mc: mc, bb: bb};
		return c;
	endfunction

	// one transfer; start stays high unless a gap follows
	task automatic xfer(cmd_t c, bit typed = 0, health_t want = '0);
		health_t p;
		action <= c.act;             source_id <= c.sid;
		config_crc <= c.cfg;         data_crc_reported <= c.drep;
		data_crc_computed <= c.dcmp; model_bytes <= c.mb;
		testpoint_bytes <= c.tb;     testpoint_count <= c.tpc;
		time_seconds <= c.tsec;      model_count <= c.mc;
		block_bytes <= c.bb;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = health_step(c);
		health_q.push_back(typed ? want : p);
		n_items++;
	endtask

	task automatic idle_gap();
		int g;
		case ($urandom_range(0, 19))
			0, 1, 2:  g = $urandom_range(1, 3);
			3:        g = $urandom_range(10, 60);
			default:  g = 0;
		endcase
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic cmd_t rand_noise();
		cmd_t c;
		c = '{act: 3'($urandom), sid: 16'($urandom), cfg: $urandom, drep: $urandom,
		      dcmp: $urandom, mb: $urandom, tb: $urandom, tpc: 16'($urandom),
		      tsec: $urandom, mc: 16'($urandom), bb: $urandom};
		return c;
	endfunction

	function automatic cmd_t rand_header(logic [31:0] room);
		cmd_t c;
		c = rand_noise();
		c.act = ACT_HDR;
		// a small working set keeps sources seen from cycle to cycle
		c.sid = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, SOURCES - 1))
		                                    : 16'($urandom_range(1, 12));
		if ($urandom_range(0, 19) == 0)
			c.sid = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(SOURCES, 65535));
		if ($urandom_range(0, 4) != 0)
			c.cfg = crc_tbl[c.sid[IDX_W-1:0]];
		if ($urandom_range(0, 4) != 0)
			c.dcmp = c.drep;
		c.mb = $urandom_range(0, room / 8);
		c.tb = $urandom_range(0, room / 16);
		if ($urandom_range(0, 24) == 0)
			c.mb = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			c.mb = 0;
			c.tb = 0;
		end
		return c;
	endfunction

	row_t    rows[$];
	health_t ack, rd0;

	initial begin
		cmd_t c;
		int   nh;
		bit   drained;
		drained = 0;
		table_reset();
		ack = '0;
		rd0 = '0;
		rd0.kind = KIND_READOUT;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		rows.push_back('{mk(ACT_READ, 0), 1, rd0});
		rows.push_back('{mk(ACT_READ, 16'hffff), 1, rd0});
		rows.push_back('{mk(ACT_LOAD, 5, 32'hffff_ffff), 1, ack});
		rows.push_back('{mk(ACT_LOAD, 255, 32'h1234_5678), 1, ack});
		rows.push_back('{mk(ACT_LOAD, 300, 32'hdead_beef), 1, ack});
		rows.push_back('{mk(ACT_UNUSED_LO), 1, ack});
		rows.push_back('{mk(ACT_UNUSED_HI, 16'hffff, 32'hffff_ffff), 1, ack});
		rows.push_back('{mk(ACT_HDR, 5, 0, 100), 1, ack});      // header with no cycle open
		rows.push_back('{mk(ACT_END), 1, ack});                  // end with no cycle open
		rows.push_back('{mk(ACT_BEGIN, 0, 0, 0, 0, 0, 1000), 1, ack});        // zero count
		rows.push_back('{mk(ACT_READ, 5), 1, '{KIND_READOUT, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0}});
		rows.push_back('{mk(ACT_BEGIN, 0, 0, 0, 0, 257, 1000), 0, ack});      // count too big
		rows.push_back('{mk(ACT_BEGIN, 0, 0, 0, 0, 1, 0), 0, ack});           // empty block
		rows.push_back('{mk(ACT_BEGIN, 0, 0, 0, 0, 256, 32'hffff_ffff), 0, ack});
		c = mk(ACT_HDR, 5, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		c.drep = 32'hffff_ffff; c.tpc = 16'hffff; c.tsec = 32'hffff_ffff;
		rows.push_back('{c, 0, ack});                            // data crc mismatch
		rows.push_back('{mk(ACT_HDR, 0), 0, ack});               // bad id, no data
		rows.push_back('{mk(ACT_HDR, 255, 0, 0, 0), 0, ack});    // config mismatch
		rows.push_back('{mk(ACT_HDR, 0, 0, 1), 0, ack});         // bad id with data: abort
		rows.push_back('{mk(ACT_HDR, 7, 0, 1), 0, ack});         // after abort
		rows.push_back('{mk(ACT_END), 0, ack});                  // charges a second time
		rows.push_back('{mk(ACT_READ, 255), 0, ack});
		rows.push_back('{mk(ACT_CLEAR), 0, ack});
		rows.push_back('{mk(ACT_BEGIN, 0, 0, 0, 0, 1, 100), 0, ack});
		rows.push_back('{mk(ACT_HDR, 7, 0, 200), 0, ack});       // overflow abort
		rows.push_back('{mk(ACT_END), 0, ack});
		rows.push_back('{mk(ACT_READ, 7), 0, ack});
		foreach (rows[i]) begin
			xfer(rows[i].c, rows[i].typed, rows[i].want);
			idle_gap();
		end

		// random data cycles with noise in between
		while (n_items < N_ITEMS) begin
			if (n_items > N_ITEMS / 2 && !drained) begin
				// hold off until every result is back
				drained = 1;
				start <= 1'b0;
				while (health_q.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 19))
				0: xfer(rand_noise());
				1: begin
					c = rand_noise();
					c.act = ACT_LOAD;
					c.sid = 16'($urandom_range(0, 15));
					xfer(c);
				end
				2: begin
					c = rand_noise();
					c.act = ACT_READ;
					c.sid = ($urandom_range(0, 7) == 0) ? 16'($urandom)
					                                    : 16'($urandom_range(0, 15));
					xfer(c);
				end
				3: begin
					c = rand_noise();
					c.act = ACT_CLEAR;
					xfer(c);
				end
				default: begin
					c = rand_noise();
					c.act = ACT_BEGIN;
					c.mc = 16'($urandom_range(1, SOURCES));
					c.bb = $urandom_range(4096, 200000);
					if ($urandom_range(0, 29) == 0)
						c.bb = $urandom;
					if ($urandom_range(0, 19) == 0)
						c.mc = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(257, 65535));
					xfer(c);
					idle_gap();
					nh = $urandom_range(0, 6);
					for (int h = 0; h < nh; h++) begin
						xfer(rand_header(c.bb));
						idle_gap();
					end
					c = rand_noise();
					c.act = ACT_END;
					xfer(c);
					if ($urandom_range(0, 2) == 0) begin
						idle_gap();
						c.act = ACT_READ;
						c.sid = 16'($urandom_range(0, 15));
						xfer(c);
					end
				end
			endcase
			idle_gap();
		end
		start <= 1'b0;

		while (health_q.size() != 0) @(posedge clk);
		repeat (2 * SOURCES + 20) @(posedge clk);
		$display("%0d commands, %0d data cycles aborted, %0d readouts, %0d summaries checked",
		         n_items, n_aborts, n_readouts, n_summaries);
		if (n_bad == 0 && health_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", n_bad, health_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// result side: done is a one-cycle strobe, sampled at the closing edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		health_t got, want;
		if (done) begin
			got = '{kind, source_status, errors_this_second, errors_total, uptime_count,
			        gps_seconds, testpoint_kib, model_kib, total_kib, open_testpoints,
			        unique_sources};
			if (health_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("result with nothing expected: kind %0d", kind);
			end else begin
				want = health_q.pop_front();
				if (got.kind == KIND_SUMMARY) n_summaries++;
				if (got.kind == KIND_READOUT) n_readouts++;
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("mismatch: kind %0d/%0d status %h/%h err %0d,%0d/%0d,%0d",
						         want.kind, got.kind, want.status, got.status,
						         want.err_sec, want.err_tot, got.err_sec, got.err_tot);
						$display("  up %0d/%0d gps %h/%h kib %0d,%0d,%0d/%0d,%0d,%0d",
						         want.uptime, got.uptime, want.gps, got.gps,
						         want.tp_kib, want.mod_kib, want.tot_kib,
						         got.tp_kib, got.mod_kib, got.tot_kib);
						$display("  open tp %0d/%0d unique %0d/%0d",
						         want.open_tp, got.open_tp, want.uniq, got.uniq);
					end
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d results outstanding", health_q.size());
		$display("Simulation FAILED");
		$finish;
	end
endmodule
